### rtl/pkf_pkg.sv
// ----------------------------------------------------------------------------
// pkf_pkg: shared types and constants of the packet framer
// Holds the frame step codes, the queue word type and the CRC-16 byte fold.
// ----------------------------------------------------------------------------
package pkf_pkg;

	localparam int PAYLOAD_BYTES_DEF = 48;
	localparam int QUEUE_DEPTH_DEF   = 4;

	localparam logic [7:0]  MARK_A  = 8'hAA;
	localparam logic [7:0]  MARK_B  = 8'h55;
	localparam logic [15:0] POLY16  = 16'h1021;
	localparam logic [15:0] TOPBIT  = 16'h8000;
	localparam int          LEN_ADD = 9;

	// Output step codes; the header runs from STEP_MARK_A0 to STEP_SEQ_LO.
	localparam logic [3:0] STEP_MARK_A0 = 4'd0;
	localparam logic [3:0] STEP_MARK_A1 = 4'd1;
	localparam logic [3:0] STEP_MARK_B0 = 4'd2;
	localparam logic [3:0] STEP_MARK_B1 = 4'd3;
	localparam logic [3:0] STEP_LENGTH  = 4'd4;
	localparam logic [3:0] STEP_SOURCE  = 4'd5;
	localparam logic [3:0] STEP_DEST    = 4'd6;
	localparam logic [3:0] STEP_TYPE    = 4'd7;
	localparam logic [3:0] STEP_SEQ_HI  = 4'd8;
	localparam logic [3:0] STEP_SEQ_LO  = 4'd9;
	localparam logic [3:0] STEP_PAYLOAD = 4'd10;
	localparam logic [3:0] STEP_CRC_HI  = 4'd11;
	localparam logic [3:0] STEP_CRC_LO  = 4'd12;

	// One classified input word as it travels from the front to the back.
	typedef struct packed {
		logic        first;
		logic        last;
		logic [7:0]  source_id;
		logic [7:0]  dest_id;
		logic [7:0]  message_type;
		logic [15:0] sequence_req;
		logic [7:0]  payload_byte;
	} cmd_t;

	function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] a;
		a = acc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((a & TOPBIT) != 16'h0000) begin
				a = {a[14:0], 1'b0} ^ POLY16;
			end else begin
				a = {a[14:0], 1'b0};
			end
		end
		return a;
	endfunction

endpackage

### rtl/pkf_front.sv
// ----------------------------------------------------------------------------
// pkf_front: input side of the packet framer
// Accepts payload words, tracks the position in the frame and marks the first
// and last word of each frame before handing it to the queue.
// ----------------------------------------------------------------------------
module pkf_front #(
	parameter int PAYLOAD_BYTES = pkf_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    source_id,
	input  logic [7:0]    dest_id,
	input  logic [7:0]    message_type,
	input  logic [15:0]   sequence_req,
	input  logic [7:0]    payload_byte,
	output logic          push,
	output pkf_pkg::cmd_t push_cmd,
	input  logic          queue_full
);
	import pkf_pkg::*;

	localparam logic [7:0] LAST_POS = 8'(PAYLOAD_BYTES - 1);

	logic [7:0] pos_q;
	logic       is_first;
	logic       is_last;

	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;

	// A position past the end cannot occur, but it would start a new frame.
	assign is_first = (pos_q == 8'd0) || (pos_q > LAST_POS);
	assign is_last  = is_first ? (LAST_POS == 8'd0) : (pos_q == LAST_POS);

	always_comb begin
		push_cmd.first        = is_first;
		push_cmd.last         = is_last;
		push_cmd.source_id    = source_id;
		push_cmd.dest_id      = dest_id;
		push_cmd.message_type = message_type;
		push_cmd.sequence_req = sequence_req;
		push_cmd.payload_byte = payload_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 8'd0;
		end else if (push) begin
			if (is_last) begin
				pos_q <= 8'd0;
			end else if (is_first) begin
				pos_q <= 8'd1;
			end else begin
				pos_q <= pos_q + 8'd1;
			end
		end
	end

endmodule

### rtl/pkf_queue.sv
// ----------------------------------------------------------------------------
// pkf_queue: short word queue between front and back
// A small register FIFO that lets the input and the frame sequencer stall
// independently of each other.
// ----------------------------------------------------------------------------
module pkf_queue #(
	parameter int DEPTH = pkf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pkf_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output pkf_pkg::cmd_t head_cmd
);
	import pkf_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + AW'(1);
			end
			if ((push && !full) && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (!(push && !full) && do_pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

### rtl/pkf_back.sv
// ----------------------------------------------------------------------------
// pkf_back: frame sequencer of the packet framer
// Expands each queued word into its frame bytes, one per cycle unless stalled,
// folds the covered bytes into the CRC and drives the registered output.
// ----------------------------------------------------------------------------
module pkf_back #(
	parameter int PAYLOAD_BYTES = pkf_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  pkf_pkg::cmd_t head_cmd,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    frame_byte,
	output logic          last_of_run,
	output logic          frame_end
);
	import pkf_pkg::*;

	localparam logic [7:0] LEN_BYTE = 8'(PAYLOAD_BYTES + LEN_ADD);

	logic        started_q;
	logic [3:0]  step_q;
	logic [15:0] crc_q;
	logic        ov_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        end_q;

	logic [3:0]  cur_step;
	logic [7:0]  cur_byte;
	logic        fire;
	logic        final_step;
	logic        covered;

	assign cur_step   = started_q ? step_q : (head_cmd.first ? STEP_MARK_A0 : STEP_PAYLOAD);
	assign fire       = head_valid && (!ov_q || out_ready);
	assign final_step = ((cur_step == STEP_PAYLOAD) && !head_cmd.last) ||
	                    (cur_step == STEP_CRC_LO);
	assign pop        = fire && final_step;
	assign covered    = (cur_step >= STEP_DEST) && (cur_step <= STEP_PAYLOAD);

	always_comb begin
		unique case (cur_step)
			STEP_MARK_A0, STEP_MARK_A1: cur_byte = MARK_A;
			STEP_MARK_B0, STEP_MARK_B1: cur_byte = MARK_B;
			STEP_LENGTH:                cur_byte = LEN_BYTE;
			STEP_SOURCE:                cur_byte = head_cmd.source_id;
			STEP_DEST:                  cur_byte = head_cmd.dest_id;
			STEP_TYPE:                  cur_byte = head_cmd.message_type;
			STEP_SEQ_HI:                cur_byte = head_cmd.sequence_req[15:8];
			STEP_SEQ_LO:                cur_byte = head_cmd.sequence_req[7:0];
			STEP_PAYLOAD:               cur_byte = head_cmd.payload_byte;
			STEP_CRC_HI:                cur_byte = crc_q[15:8];
			STEP_CRC_LO:                cur_byte = crc_q[7:0];
			default:                    cur_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			step_q    <= STEP_MARK_A0;
			crc_q     <= 16'h0000;
			ov_q      <= 1'b0;
		end else begin
			if (fire) begin
				started_q <= !final_step;
				step_q    <= cur_step + 4'd1;
				ov_q      <= 1'b1;
				if (covered) begin
					crc_q <= crc_fold(crc_q, cur_byte);
				end else if (cur_step == STEP_CRC_LO) begin
					crc_q <= 16'h0000;
				end
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q <= cur_byte;
			last_q <= final_step;
			end_q  <= (cur_step == STEP_CRC_LO);
		end
	end

	assign out_valid   = ov_q;
	assign frame_byte  = byte_q;
	assign last_of_run = last_q;
	assign frame_end   = end_q;

endmodule

### rtl/packet_framer_crc16.sv
// ----------------------------------------------------------------------------
// packet_framer_crc16: radio frame builder with CRC-16 check value
// Turns a stream of payload words into framed bytes with header and CRC.
// ----------------------------------------------------------------------------
// Each input word carries one payload byte; the header fields are taken only
// with the first word of a frame. The frame sequencer emits one byte per cycle,
// while out_ready does not stall it, into a registered output, so a middle
// payload word yields one byte, the first word of a frame eleven bytes (ten
// header bytes plus the payload byte) and the last word three bytes (payload
// byte and two CRC bytes). A four-word queue between input and sequencer keeps
// taking words while the header burst drains, so a frame of PAYLOAD_BYTES words
// gives PAYLOAD_BYTES + 12 output bytes. The CRC (polynomial 0x1021, init 0, no
// final xor) covers the destination id onward and leaves out the source id.
module packet_framer_crc16 #(
	parameter int PAYLOAD_BYTES = pkf_pkg::PAYLOAD_BYTES_DEF,
	parameter int QUEUE_DEPTH   = pkf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  source_id,
	input  logic [7:0]  dest_id,
	input  logic [7:0]  message_type,
	input  logic [15:0] sequence_req,
	input  logic [7:0]  payload_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_byte,
	output logic        last_of_run,
	output logic        frame_end
);
	import pkf_pkg::*;

	logic push;
	logic queue_full;
	logic pop;
	logic head_valid;
	cmd_t push_cmd;
	cmd_t head_cmd;

	pkf_front #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.source_id   (source_id),
		.dest_id     (dest_id),
		.message_type(message_type),
		.sequence_req(sequence_req),
		.payload_byte(payload_byte),
		.push        (push),
		.push_cmd    (push_cmd),
		.queue_full  (queue_full)
	);

	pkf_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (queue_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_cmd  (head_cmd)
	);

	pkf_back #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_byte (frame_byte),
		.last_of_run(last_of_run),
		.frame_end  (frame_end)
	);

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the CRC-16 packet framer
// Feeds payload words with random header fields over valid/ready, predicts
// every frame byte with its own CRC and position tracking, and compares the
// output stream in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------

class frame_scoreboard;

	typedef struct {
		logic [7:0] value;
		logic       run_last;
		logic       frame_last;
	} air_byte_t;

	air_byte_t   air_q[$];
	int unsigned payload_len;
	logic [7:0]  position;
	logic [15:0] crc;
	int unsigned errors;

	function new(int unsigned len);
		payload_len = len;
		position    = 8'd0;
		crc         = 16'h0000;
		errors      = 0;
	endfunction

	// Bit-serial form of the MSB-first CRC; the feedback is the top bit xor data bit.
	function logic [15:0] crc_step(logic [15:0] acc, logic [7:0] b);
		logic [15:0] r;
		r = acc;
		for (int i = 7; i >= 0; i--) begin
			if (r[15] ^ b[i]) begin
				r = {r[14:0], 1'b0} ^ pkf_pkg::POLY16;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return r;
	endfunction

	function void push_byte(logic [7:0] v, logic fl);
		air_byte_t e;
		e.value      = v;
		e.run_last   = 1'b0;
		e.frame_last = fl;
		air_q.push_back(e);
	endfunction

	function void note_word(logic [7:0] src, logic [7:0] dst, logic [7:0] typ,
			logic [15:0] seq, logic [7:0] pay);
		if (position >= payload_len) begin
			position = 8'd0;
		end
		if (position == 8'd0) begin
			push_byte(pkf_pkg::MARK_A, 1'b0);
			push_byte(pkf_pkg::MARK_A, 1'b0);
			push_byte(pkf_pkg::MARK_B, 1'b0);
			push_byte(pkf_pkg::MARK_B, 1'b0);
			push_byte(8'(payload_len + pkf_pkg::LEN_ADD), 1'b0);
			push_byte(src, 1'b0);
			push_byte(dst, 1'b0);
			push_byte(typ, 1'b0);
			push_byte(seq[15:8], 1'b0);
			push_byte(seq[7:0], 1'b0);
			// The source id is sent but stays outside the check value.
			crc = crc_step(16'h0000, dst);
			crc = crc_step(crc, typ);
			crc = crc_step(crc, seq[15:8]);
			crc = crc_step(crc, seq[7:0]);
		end
		push_byte(pay, 1'b0);
		crc = crc_step(crc, pay);
		if (position + 1 >= payload_len) begin
			push_byte(crc[15:8], 1'b0);
			push_byte(crc[7:0], 1'b1);
			position = 8'd0;
			crc      = 16'h0000;
		end else begin
			position = position + 8'd1;
		end
		air_q[air_q.size() - 1].run_last = 1'b1;
	endfunction

	function void check_byte(logic [7:0] v, logic rl, logic fl);
		air_byte_t e;
		if (air_q.size() == 0) begin
			errors++;
			if (errors <= 10) begin
				$display("unexpected byte: frame_byte=%02h last_of_run=%0b frame_end=%0b",
					v, rl, fl);
			end
			return;
		end
		e = air_q.pop_front();
		if (e.value !== v || e.run_last !== rl || e.frame_last !== fl) begin
			errors++;
			if (errors <= 10) begin
				$display("byte mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
					e.value, e.run_last, e.frame_last, v, rl, fl);
			end
		end
	endfunction

endclass

module tb_top;

	localparam int FRAME_LEN   = pkf_pkg::PAYLOAD_BYTES_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int RAND_WORDS  = 50;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic [7:0]  source_id    = 8'h00;
	logic [7:0]  dest_id      = 8'h00;
	logic [7:0]  message_type = 8'h00;
	logic [15:0] sequence_req = 16'h0000;
	logic [7:0]  payload_byte = 8'h00;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [7:0]  frame_byte;
	logic        last_of_run;
	logic        frame_end;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned cycle_count    = 0;
	logic        hold_off       = 1'b0;
	logic        pressure_go    = 1'b0;

	frame_scoreboard sb;

	packet_framer_crc16 #(
		.PAYLOAD_BYTES(FRAME_LEN)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.source_id    (source_id),
		.dest_id      (dest_id),
		.message_type (message_type),
		.sequence_req (sequence_req),
		.payload_byte (payload_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_byte   (frame_byte),
		.last_of_run  (last_of_run),
		.frame_end    (frame_end)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: ready is decided at the falling edge, words are taken at the rising edge.
	always @(negedge clk) begin
		if (!arst_n || hold_off) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_byte(frame_byte, last_of_run, frame_end);
		end
	end

	// Long receiver hold-off so the input queue fills and in_ready drops.
	initial begin
		wait (pressure_go);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	function automatic logic [7:0] pick8();
		case ($urandom_range(3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick16();
		case ($urandom_range(3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Offer one word from a falling edge and return at the falling edge after acceptance.
	task automatic send_word(logic [7:0] src, logic [7:0] dst, logic [7:0] typ,
			logic [15:0] seq, logic [7:0] pay);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		source_id    <= src;
		dest_id      <= dst;
		message_type <= typ;
		sequence_req <= seq;
		payload_byte <= pay;
		do begin
			@(posedge clk);
		end while (!in_ready);
		sb.note_word(src, dst, typ, seq, pay);
		@(negedge clk);
	endtask

	initial begin
		logic [7:0]  edge_pay[8];
		int unsigned idle_by_phase[4];
		int unsigned stall_by_phase[4];
		edge_pay       = '{8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'hFF, 8'h00};
		idle_by_phase  = '{0, 63, 0, 17};
		stall_by_phase = '{0, 0, 63, 17};
		sb = new(FRAME_LEN);
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Frame start with all header fields at zero, then a word whose header
		// fields are at the other extreme and must be ignored, then random fields.
		send_word(8'h00, 8'h00, 8'h00, 16'h0000, 8'h00);
		send_word(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
		for (int i = 0; i < 22; i++) begin
			send_word(pick8(), pick8(), pick8(), pick16(), edge_pay[i % 8]);
		end

		// Random words; frame starts land on random header values, extremes included.
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = idle_by_phase[p];
			recv_stall_pct = stall_by_phase[p];
			if (p == 0) begin
				pressure_go = 1'b1;
			end
			for (int i = 0; i < RAND_WORDS; i++) begin
				send_word(pick8(), pick8(), pick8(), pick16(), pick8());
			end
		end
		in_valid       <= 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;

		while (sb.air_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.air_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
